@@ hdl/binary_min_heap_queue_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue core
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Assertion on an explicit clock and active-low reset.
`define BMHQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Assertion on the block's own clock and reset.
`define BMHQ_ASSERT(lbl, prop, msg) `BMHQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define BMHQ_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define BMHQ_ASSERT(lbl, prop, msg)
`endif
`endif

@@ hdl/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// Sizes, codes and shared types of the binary min-heap queue core.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int HEAP_DEPTH = 128;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W      = ADDR_W + 2;
  localparam int KEY_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 8;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Datapath commands issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_FULL,
    CMD_SET_EMPTY,
    CMD_INS_START,
    CMD_RD_ROOT,
    CMD_RD_LAST,
    CMD_TAKE_LAST,
    CMD_UP_RD,
    CMD_UP_MOVE,
    CMD_PLACE_KEY,
    CMD_DN_RD_L,
    CMD_DN_RD_R,
    CMD_DN_MOVE,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic op_extract;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_swap;
    logic left_in;
    logic dn_stop;
    logic out_free;
  } dp_status_t;

  // Low bits of the entry count as carried by the result word.
  function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] ext;
    ext = {{COUNT_W{1'b0}}, c};
    return ext[COUNT_W-1:0];
  endfunction

endpackage

@@ hdl/bmhq_req_if.sv @@
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel: opcode and key with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic signed [bmhq_pkg::KEY_W-1:0]   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ hdl/bmhq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// Result channel: minimum, status and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface bmhq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bmhq_pkg::KEY_W-1:0]    min_value;
  logic        [bmhq_pkg::STATUS_W-1:0] status;
  logic        [bmhq_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output min_value, output status, output count, input ready);
  modport sink   (input valid, input min_value, input status, input count, output ready);
endinterface

@@ hdl/bmhq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/bmhq_dpath.sv @@
// ----------------------------------------------------------------------------
// bmhq_dpath
// Heap datapath: key store, entry count, sift position, compares and the
// result register.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_core_macros.svh"

module bmhq_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bmhq_pkg::cmd_e                      cmd_i,
  input  logic                                opcode_i,
  input  logic signed [bmhq_pkg::KEY_W-1:0]   value_i,
  input  logic                                rsp_ready_i,
  output bmhq_pkg::dp_status_t                sts_o,
  output logic                                rsp_valid_o,
  output logic signed [bmhq_pkg::KEY_W-1:0]   rsp_min_value_o,
  output logic        [bmhq_pkg::STATUS_W-1:0] rsp_status_o,
  output logic        [bmhq_pkg::COUNT_W-1:0]  rsp_count_o
);

  localparam int ADDR_W = bmhq_pkg::ADDR_W;
  localparam int CNT_W  = bmhq_pkg::CNT_W;
  localparam int CMP_W  = bmhq_pkg::CMP_W;
  localparam int KEY_W  = bmhq_pkg::KEY_W;

  logic                        op_q, op_d;
  logic signed [KEY_W-1:0]     key_q, key_d;
  logic signed [KEY_W-1:0]     left_q, left_d;
  logic signed [KEY_W-1:0]     min_q, min_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [ADDR_W-1:0]           pos_q, pos_d;
  bmhq_pkg::status_e           st_q, st_d;

  logic                            out_valid_q, out_valid_d;
  logic signed [KEY_W-1:0]         out_min_q, out_min_d;
  bmhq_pkg::status_e               out_st_q, out_st_d;
  logic [bmhq_pkg::COUNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [KEY_W-1:0]    wr_data, rd_data;
  logic signed [KEY_W-1:0] rd_key;

  logic [ADDR_W-1:0]   pos_m1, parent_addr;
  logic [CMP_W-1:0]    left_w, right_w, n_w;
  logic [CNT_W-1:0]    cnt_m1;
  logic                left_in, right_in, left_lt, right_lt, dn_stop, up_swap, out_free;
  logic signed [KEY_W-1:0] best_key;

  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (bmhq_pkg::HEAP_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_key      = $signed(rd_data);
  assign pos_m1      = pos_q - ADDR_W'(1);
  assign parent_addr = pos_m1 >> 1;
  assign left_w      = {1'b0, pos_q, 1'b1};
  assign right_w     = left_w + CMP_W'(1);
  assign n_w         = CMP_W'(count_q);
  assign cnt_m1      = count_q - CNT_W'(1);
  assign left_in     = left_w < n_w;
  assign right_in    = right_w < n_w;

  // The left child value is held in left_q; the right child value arrives
  // on the read port in the compare cycle.
  assign left_lt  = left_q < key_q;
  assign best_key = left_lt ? left_q : key_q;
  assign right_lt = right_in && (rd_key < best_key);
  assign dn_stop  = !left_lt && !right_lt;
  assign up_swap  = key_q < rd_key;
  assign out_free = !out_valid_q || rsp_ready_i;

  assign sts_o.op_extract = (op_q == bmhq_pkg::OP_EXTRACT);
  assign sts_o.full       = (count_q == CNT_W'(bmhq_pkg::HEAP_DEPTH));
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.up_swap    = up_swap;
  assign sts_o.left_in    = left_in;
  assign sts_o.dn_stop    = dn_stop;
  assign sts_o.out_free   = out_free;

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    left_d      = left_q;
    min_d       = min_q;
    count_d     = count_q;
    pos_d       = pos_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    out_min_d   = out_min_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = key_q;
    case (cmd_i)
      bmhq_pkg::CMD_LOAD: begin
        op_d  = opcode_i;
        key_d = value_i;
        min_d = '0;
        st_d  = bmhq_pkg::ST_OK;
      end
      bmhq_pkg::CMD_SET_FULL: begin
        st_d = bmhq_pkg::ST_FULL;
      end
      bmhq_pkg::CMD_SET_EMPTY: begin
        st_d = bmhq_pkg::ST_EMPTY;
      end
      bmhq_pkg::CMD_INS_START: begin
        pos_d   = count_q[ADDR_W-1:0];
        count_d = count_q + CNT_W'(1);
      end
      bmhq_pkg::CMD_RD_ROOT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      bmhq_pkg::CMD_RD_LAST: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[ADDR_W-1:0];
        min_d   = rd_key;
        count_d = cnt_m1;
      end
      bmhq_pkg::CMD_TAKE_LAST: begin
        key_d = rd_key;
        pos_d = '0;
      end
      bmhq_pkg::CMD_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = parent_addr;
      end
      bmhq_pkg::CMD_UP_MOVE: begin
        // The parent drops into the hole and the hole moves up.
        wr_en   = 1'b1;
        wr_data = rd_data;
        pos_d   = parent_addr;
      end
      bmhq_pkg::CMD_PLACE_KEY: begin
        wr_en   = 1'b1;
        wr_data = key_q;
      end
      bmhq_pkg::CMD_DN_RD_L: begin
        rd_en   = 1'b1;
        rd_addr = left_w[ADDR_W-1:0];
      end
      bmhq_pkg::CMD_DN_RD_R: begin
        left_d  = rd_key;
        rd_en   = right_in;
        rd_addr = right_w[ADDR_W-1:0];
      end
      bmhq_pkg::CMD_DN_MOVE: begin
        wr_en = 1'b1;
        if (right_lt) begin
          wr_data = rd_data;
          pos_d   = right_w[ADDR_W-1:0];
        end else begin
          wr_data = left_q;
          pos_d   = left_w[ADDR_W-1:0];
        end
      end
      bmhq_pkg::CMD_EMIT: begin
        out_valid_d = 1'b1;
        out_min_d   = min_q;
        out_st_d    = st_q;
        out_cnt_d   = bmhq_pkg::count_field(count_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    left_q    <= left_d;
    min_q     <= min_d;
    pos_q     <= pos_d;
    st_q      <= st_d;
    out_min_q <= out_min_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  assign rsp_valid_o     = out_valid_q;
  assign rsp_min_value_o = out_min_q;
  assign rsp_status_o    = out_st_q;
  assign rsp_count_o     = out_cnt_q;

  `BMHQ_ASSERT(a_count_range, count_q <= CNT_W'(bmhq_pkg::HEAP_DEPTH), "entry count beyond depth")
  `BMHQ_ASSERT(a_emit_free, (cmd_i == bmhq_pkg::CMD_EMIT) |-> out_free, "result overwritten")
  `BMHQ_ASSERT(a_emit_valid, (cmd_i == bmhq_pkg::CMD_EMIT) |=> out_valid_q, "result not shown")
  `BMHQ_ASSERT(a_up_nonroot, (cmd_i == bmhq_pkg::CMD_UP_MOVE) |-> (pos_q != '0), "root moved up")
  `BMHQ_ASSERT(a_last_nonempty, (cmd_i == bmhq_pkg::CMD_RD_LAST) |-> (count_q != '0),
               "extract from empty heap")

endmodule

@@ hdl/bmhq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller: sequences insert and extract requests over the datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bmhq_pkg::dp_status_t sts_i,
  output bmhq_pkg::cmd_e       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHECK,
    S_UP_CMP,
    S_EX_LAST,
    S_EX_TAKE,
    S_DN_CHECK,
    S_DN_RD_R,
    S_DN_CMP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;

  always_comb begin
    state_d    = state_q;
    in_ready_d = in_ready_q;
    cmd_o      = bmhq_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o      = bmhq_pkg::CMD_LOAD;
          in_ready_d = 1'b0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts_i.op_extract) begin
          if (sts_i.full) begin
            cmd_o   = bmhq_pkg::CMD_SET_FULL;
            state_d = S_FINISH;
          end else begin
            cmd_o   = bmhq_pkg::CMD_INS_START;
            state_d = S_UP_CHECK;
          end
        end else if (sts_i.empty) begin
          cmd_o   = bmhq_pkg::CMD_SET_EMPTY;
          state_d = S_FINISH;
        end else begin
          cmd_o   = bmhq_pkg::CMD_RD_ROOT;
          state_d = S_EX_LAST;
        end
      end
      S_UP_CHECK: begin
        if (sts_i.pos_zero) begin
          cmd_o   = bmhq_pkg::CMD_PLACE_KEY;
          state_d = S_FINISH;
        end else begin
          cmd_o   = bmhq_pkg::CMD_UP_RD;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.up_swap) begin
          cmd_o   = bmhq_pkg::CMD_UP_MOVE;
          state_d = S_UP_CHECK;
        end else begin
          cmd_o   = bmhq_pkg::CMD_PLACE_KEY;
          state_d = S_FINISH;
        end
      end
      S_EX_LAST: begin
        cmd_o   = bmhq_pkg::CMD_RD_LAST;
        state_d = S_EX_TAKE;
      end
      S_EX_TAKE: begin
        cmd_o   = bmhq_pkg::CMD_TAKE_LAST;
        state_d = S_DN_CHECK;
      end
      S_DN_CHECK: begin
        if (sts_i.left_in) begin
          cmd_o   = bmhq_pkg::CMD_DN_RD_L;
          state_d = S_DN_RD_R;
        end else begin
          cmd_o   = bmhq_pkg::CMD_PLACE_KEY;
          state_d = S_FINISH;
        end
      end
      S_DN_RD_R: begin
        cmd_o   = bmhq_pkg::CMD_DN_RD_R;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.dn_stop) begin
          cmd_o   = bmhq_pkg::CMD_PLACE_KEY;
          state_d = S_FINISH;
        end else begin
          cmd_o   = bmhq_pkg::CMD_DN_MOVE;
          state_d = S_DN_CHECK;
        end
      end
      S_FINISH: begin
        // Hold the finished word until the result register is free.
        if (sts_i.out_free) begin
          cmd_o      = bmhq_pkg::CMD_EMIT;
          in_ready_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d    = S_IDLE;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

@@ hdl/binary_min_heap_queue_core.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Min-heap priority queue over a single-read-port key store.
//
//   Channel  Dir  Word contents
//   req_i    in   opcode (0 insert, 1 extract), value (signed 32 bits)
//   rsp_o    out  min_value (signed 32 bits), status (2 bits), count (8 bits)
//
// An insert moves its hole up one parent step at a time, and an extract sinks
// the last entry one child step at a time; one store read per parent step, two
// per child step (one where the node has no right child). A dropped insert or
// an empty extract reads no store entry. Reset empties the queue at once; the
// store needs no clearing pass.
// A new request is taken while a finished word waits in the result register.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bmhq_req_if.sink   req_i,
  bmhq_rsp_if.source rsp_o
);

  bmhq_pkg::cmd_e       cmd;
  bmhq_pkg::dp_status_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmhq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .opcode_i        (req_i.opcode),
    .value_i         (req_i.value),
    .rsp_ready_i     (rsp_o.ready),
    .sts_o           (sts),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_min_value_o (rsp_o.min_value),
    .rsp_status_o    (rsp_o.status),
    .rsp_count_o     (rsp_o.count)
  );

endmodule
